>>> sv/s_curve_speed_profile_macros.svh
// ---------------------------------------------------------------------------
// S-curve speed profile assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef S_CURVE_SPEED_PROFILE_MACROS_SVH
`define S_CURVE_SPEED_PROFILE_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define SCSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scsp assertion failed");

// checked at every edge, reset included
`define SCSP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("scsp assertion failed");

`else

`define SCSP_ASSERT(lbl, clk, rst, prop)
`define SCSP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> sv/scsp_pkg.sv
// ---------------------------------------------------------------------------
// S-curve speed profile package
// Widths, register indexes and the Q2.62 exponential base constants.
// ---------------------------------------------------------------------------
package scsp_pkg;

   localparam int MAG_W      = 13;
   localparam int MAX_POINTS = 1024;

   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
   localparam logic [19:0] TICKS_PER_SECOND = 20'd1000000;

   typedef enum logic [1:0] {
      REG_POINT_COUNT = 2'd0,
      REG_FREQ_HIGH   = 2'd1,
      REG_FREQ_LOW    = 2'd2,
      REG_STEEPNESS   = 2'd3
   } csr_index_type;

   typedef logic [63:0] q62_arr_type [MAG_W];

   // e^(-2^k/256) in Q2.62: Taylor series, then repeated squaring
   function automatic q62_arr_type exp_bases();
      q62_arr_type b;
      logic [63:0]  sum;
      logic [63:0]  term;
      logic [127:0] p;
      sum  = ONE_Q62;
      term = ONE_Q62;
      for (int n = 1; n < 48; n++) begin
         term = (term >> 8) / 64'(n);
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      b[0] = sum;
      for (int k = 1; k < MAG_W; k++) begin
         p    = 128'(b[k-1]) * 128'(b[k-1]);
         b[k] = p[125:62];
      end
      return b;
   endfunction

   localparam q62_arr_type EXP_BASE = exp_bases();

endpackage

>>> sv/scsp_divpipe.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Q_W quotient bits, STEPS bits per register stage, side payload alongside.
// Requires num < den << Q_W.
// ---------------------------------------------------------------------------
module scsp_divpipe #(
   parameter int NUM_W  = 24,
   parameter int DEN_W  = 11,
   parameter int Q_W    = 13,
   parameter int SIDE_W = 1,
   parameter int STEPS  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NST = (Q_W + STEPS - 1) / STEPS;
   localparam int W   = NUM_W + DEN_W;

   logic [NST-1:0]    valid_ff;
   logic [NUM_W-1:0]  rem_ff  [NST];
   logic [DEN_W-1:0]  den_ff  [NST];
   logic [Q_W-1:0]    quot_ff [NST];
   logic [SIDE_W-1:0] side_ff [NST];

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic              v_i;
      logic [NUM_W-1:0]  rem_i;
      logic [NUM_W-1:0]  rem_in;
      logic [DEN_W-1:0]  den_i;
      logic [Q_W-1:0]    quot_i;
      logic [Q_W-1:0]    quot_in;
      logic [SIDE_W-1:0] side_i;

      if (s == 0) begin : g_first
         assign v_i    = in_valid;
         assign rem_i  = in_num;
         assign den_i  = in_den;
         assign quot_i = '0;
         assign side_i = in_side;
      end else begin : g_next
         assign v_i    = valid_ff[s-1];
         assign rem_i  = rem_ff[s-1];
         assign den_i  = den_ff[s-1];
         assign quot_i = quot_ff[s-1];
         assign side_i = side_ff[s-1];
      end

      always_comb begin
         logic [W-1:0] dsh;
         rem_in  = rem_i;
         quot_in = quot_i;
         dsh     = '0;
         for (int j = 0; j < STEPS; j++) begin
            if (s * STEPS + j < Q_W) begin
               dsh = W'(den_i) << (Q_W - 1 - (s * STEPS + j));
               if (W'(rem_in) >= dsh) begin
                  rem_in = rem_in - dsh[NUM_W-1:0];
                  quot_in[Q_W - 1 - (s * STEPS + j)] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_i;
            quot_ff[s] <= quot_in;
            side_ff[s] <= side_i;
         end
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_quot  = quot_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

>>> sv/scsp_exp.sv
// ---------------------------------------------------------------------------
// Exponential pipeline
// e^(-mag/256) in Q2.62: one conditional multiply per magnitude bit, each
// split into partial products (one stage) and a sum (one stage).
// ---------------------------------------------------------------------------
module scsp_exp
   import scsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [MAG_W-1:0] in_mag,
   input  logic             in_neg,
   output logic             out_valid,
   output logic [63:0]      out_e,
   output logic             out_neg
);

   logic [MAG_W-1:0] va_ff;
   logic [MAG_W-1:0] vb_ff;
   logic [MAG_W-1:0] na_ff;
   logic [MAG_W-1:0] nb_ff;
   logic [MAG_W-1:0] ma_ff [MAG_W];
   logic [MAG_W-1:0] mb_ff [MAG_W];
   logic [63:0]      ea_ff [MAG_W];
   logic [63:0]      eb_ff [MAG_W];
   logic [63:0]      ll_ff [MAG_W];
   logic [63:0]      lh_ff [MAG_W];
   logic [63:0]      hl_ff [MAG_W];
   logic [63:0]      hh_ff [MAG_W];

   for (genvar k = 0; k < MAG_W; k++) begin : g_bit
      logic             v_i;
      logic             n_i;
      logic [MAG_W-1:0] m_i;
      logic [63:0]      e_i;
      logic [127:0]     sum;
      logic [63:0]      eb_in;
      logic [31:0]      base_lo;
      logic [31:0]      base_hi;

      if (k == 0) begin : g_first
         assign v_i = in_valid;
         assign n_i = in_neg;
         assign m_i = in_mag;
         assign e_i = ONE_Q62;
      end else begin : g_next
         assign v_i = vb_ff[k-1];
         assign n_i = nb_ff[k-1];
         assign m_i = mb_ff[k-1];
         assign e_i = eb_ff[k-1];
      end

      assign base_lo = EXP_BASE[k][31:0];
      assign base_hi = EXP_BASE[k][63:32];

      always_comb begin
         sum = 128'(ll_ff[k]) + (128'(lh_ff[k]) << 32) + (128'(hl_ff[k]) << 32)
             + (128'(hh_ff[k]) << 64);
         eb_in = ma_ff[k][k] ? sum[125:62] : ea_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[k] <= 1'b0;
            vb_ff[k] <= 1'b0;
         end else if (en) begin
            va_ff[k] <= v_i;
            vb_ff[k] <= va_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ll_ff[k] <= 64'(e_i[31:0])  * 64'(base_lo);
            lh_ff[k] <= 64'(e_i[31:0])  * 64'(base_hi);
            hl_ff[k] <= 64'(e_i[63:32]) * 64'(base_lo);
            hh_ff[k] <= 64'(e_i[63:32]) * 64'(base_hi);
            ea_ff[k] <= e_i;
            ma_ff[k] <= m_i;
            na_ff[k] <= n_i;
            eb_ff[k] <= eb_in;
            mb_ff[k] <= ma_ff[k];
            nb_ff[k] <= na_ff[k];
         end
      end
   end

   assign out_valid = vb_ff[MAG_W-1];
   assign out_e     = eb_ff[MAG_W-1];
   assign out_neg   = nb_ff[MAG_W-1];

endmodule

>>> sv/s_curve_speed_profile.sv
// ---------------------------------------------------------------------------
// S-curve speed profile
// Step frequency and timer period for one point of a sigmoid ramp.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per ramp point (req_point_index). Accepted when
//            req_valid is high and req_stall is low.
//   rsp_*  : one transaction per request, in order: step frequency, timer
//            period in microsecond ticks and the saturation flag.
//   csr_*  : register writes by index (0 point_count, 1 freq_high,
//            2 freq_low, 3 steepness); csr_ready is always high. Write only
//            while no request is in flight.
// Throughput: one transaction per cycle, sustained while rsp_stall does not hold a result.
// Pipeline: 49 register stages: 1 entry, 4 for the Q5.8 argument divide,
//   26 for the exponential (13 multiplies, two stages each), 9 for the
//   sigmoid reciprocal, 3 for the frequency, 5 for the period divide and
//   1 output register.
// Stall: the pipeline freezes as a whole while a result is held on rsp_*
//   and rsp_stall is high; req_stall mirrors that condition.
// Reset: synchronous; clears all valid bits and loads the register defaults
//   (1000 points, 56000 Hz, 16000 Hz, steepness 64/16).
// ---------------------------------------------------------------------------
`include "s_curve_speed_profile_macros.svh"

module s_curve_speed_profile
   import scsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_point_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_step_freq,
   output logic [15:0] rsp_timer_period,
   output logic        rsp_period_clipped,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // config registers
   logic [10:0] point_count_ff;
   logic [15:0] freq_high_ff;
   logic [15:0] freq_low_ff;
   logic [8:0]  steepness_ff;

   // global advance: whole pipe holds while the output is stalled
   logic en;

   // entry stage
   logic        ent_valid_ff;
   logic [23:0] ent_num_ff;
   logic [23:0] ent_num_in;
   logic [10:0] ent_len_ff;
   logic [10:0] ent_len_in;
   logic        ent_neg_ff;
   logic        ent_neg_in;

   // argument divide
   logic             mag_valid;
   logic [MAG_W-1:0] mag_quot;
   logic             mag_neg;

   // exponential
   logic        exp_valid;
   logic [63:0] exp_e;
   logic        exp_neg;

   // sigmoid reciprocal
   logic        sig_valid;
   logic [17:0] sig_quot;
   logic        sig_neg;

   // frequency stages
   logic        f1_valid_ff;
   logic [16:0] f1_s_ff;
   logic [16:0] f1_s_in;
   logic [15:0] f1_span_ff;
   logic [15:0] f1_span_in;
   logic [15:0] f1_fmin_ff;
   logic [15:0] f1_fmin_in;
   logic        f2_valid_ff;
   logic [32:0] f2_prod_ff;
   logic [15:0] f2_fmin_ff;
   logic        f3_valid_ff;
   logic [15:0] f3_freq_ff;
   logic [15:0] f3_freq_in;
   logic        f3_zero_ff;

   // period divide
   logic        per_valid;
   logic [19:0] per_quot;
   logic [16:0] per_side;

   logic        rsp_valid_ff;
   logic [15:0] rsp_freq_ff;
   logic [15:0] rsp_period_ff;
   logic [15:0] rsp_period_in;
   logic        rsp_clip_ff;
   logic        rsp_clip_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // ---------------- register writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 11'd1000;
         freq_high_ff   <= 16'd56000;
         freq_low_ff    <= 16'd16000;
         steepness_ff   <= 9'd64;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_POINT_COUNT: point_count_ff <= csr_data[10:0];
            REG_FREQ_HIGH:   freq_high_ff   <= csr_data;
            REG_FREQ_LOW:    freq_low_ff    <= csr_data;
            REG_STEEPNESS:   steepness_ff   <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // ---------------- entry: clamp, distance from mid-ramp ----------------
   always_comb begin
      logic [10:0] len;
      logic [10:0] idx;
      logic [11:0] twice;
      logic [11:0] mid_gap;
      logic [20:0] prod;
      len = point_count_ff;
      if (len < 11'd2) begin
         len = 11'd2;
      end
      if (len > 11'(MAX_POINTS)) begin
         len = 11'(MAX_POINTS);
      end
      idx = {1'b0, req_point_index};
      if (idx >= len) begin
         idx = len - 11'd1;
      end
      twice      = {idx, 1'b0};
      ent_neg_in = twice < {1'b0, len};
      mid_gap    = ent_neg_in ? ({1'b0, len} - twice) : (twice - {1'b0, len});
      prod       = 21'(steepness_ff) * 21'(mid_gap);
      // times 16: steepness is in sixteenths, result in Q5.8
      ent_num_in = 24'({prod, 4'b0000});
      ent_len_in = len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (en) begin
         ent_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_num_ff <= ent_num_in;
         ent_len_ff <= ent_len_in;
         ent_neg_ff <= ent_neg_in;
      end
   end

   // ---------------- |x| in Q5.8 = num / len ----------------
   scsp_divpipe #(
      .NUM_W  (24),
      .DEN_W  (11),
      .Q_W    (MAG_W),
      .SIDE_W (1),
      .STEPS  (4)
   ) u_mag_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ent_valid_ff),
      .in_num    (ent_num_ff),
      .in_den    (ent_len_ff),
      .in_side   (ent_neg_ff),
      .out_valid (mag_valid),
      .out_quot  (mag_quot),
      .out_side  (mag_neg)
   );

   // ---------------- e^(-|x|) ----------------
   scsp_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mag_valid),
      .in_mag    (mag_quot),
      .in_neg    (mag_neg),
      .out_valid (exp_valid),
      .out_e     (exp_e),
      .out_neg   (exp_neg)
   );

   // ---------------- floor(2^79 / (1 + e)) ----------------
   scsp_divpipe #(
      .NUM_W  (80),
      .DEN_W  (64),
      .Q_W    (18),
      .SIDE_W (1),
      .STEPS  (2)
   ) u_sig_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (exp_valid),
      .in_num    ({1'b1, 79'd0}),
      .in_den    (ONE_Q62 + exp_e),
      .in_side   (exp_neg),
      .out_valid (sig_valid),
      .out_quot  (sig_quot),
      .out_side  (sig_neg)
   );

   // ---------------- frequency ----------------
   always_comb begin
      logic [18:0] rounded;
      logic [16:0] s;
      rounded    = 19'(sig_quot) + 19'd1;
      s          = rounded[17:1];
      // left half of the ramp mirrors the curve
      f1_s_in    = sig_neg ? (17'd65536 - s) : s;
      // inverted band collapses to a flat profile
      f1_fmin_in = (freq_low_ff > freq_high_ff) ? freq_high_ff : freq_low_ff;
      f1_span_in = freq_high_ff - f1_fmin_in;
   end

   assign f3_freq_in = f2_fmin_ff + f2_prod_ff[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= sig_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_s_ff    <= f1_s_in;
         f1_span_ff <= f1_span_in;
         f1_fmin_ff <= f1_fmin_in;
         f2_prod_ff <= 33'(f1_span_ff) * 33'(f1_s_ff);
         f2_fmin_ff <= f1_fmin_ff;
         f3_freq_ff <= f3_freq_in;
         f3_zero_ff <= (f3_freq_in == 16'd0);
      end
   end

   // ---------------- period = 1000000 / freq ----------------
   scsp_divpipe #(
      .NUM_W  (20),
      .DEN_W  (16),
      .Q_W    (20),
      .SIDE_W (17),
      .STEPS  (4)
   ) u_per_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f3_valid_ff),
      .in_num    (TICKS_PER_SECOND),
      .in_den    (f3_freq_ff),
      .in_side   ({f3_zero_ff, f3_freq_ff}),
      .out_valid (per_valid),
      .out_quot  (per_quot),
      .out_side  (per_side)
   );

   // saturate: zero frequency or a period beyond 16 bits
   always_comb begin
      rsp_clip_in   = per_side[16] || (per_quot[19:16] != 4'd0);
      rsp_period_in = rsp_clip_in ? 16'hFFFF : per_quot[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= per_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_freq_ff   <= per_side[15:0];
         rsp_period_ff <= rsp_period_in;
         rsp_clip_ff   <= rsp_clip_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_freq      = rsp_freq_ff;
   assign rsp_timer_period   = rsp_period_ff;
   assign rsp_period_clipped = rsp_clip_ff;

   // ---------------- assertions ----------------
   `SCSP_ASSERT(a_clip_saturates, clock, reset,
      rsp_valid && rsp_period_clipped |-> rsp_timer_period == 16'hFFFF)
   `SCSP_ASSERT(a_clip_only_low_freq, clock, reset,
      rsp_valid && !rsp_period_clipped |-> rsp_step_freq >= 16'd16)
   `SCSP_ASSERT_ALWAYS(a_reset_empties, clock,
      $past(reset) |-> !rsp_valid)

endmodule
